// File: rtl/usf_pkg.sv
// Shared types and constants for the universal sink finder.
package usf_pkg;

  localparam int ROW_W   = 32;
  localparam int IDX_W   = 5;
  localparam int COUNT_W = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;         // store the accepted row
    logic start;      // latch n, candidate 0, counter 1
    logic rd;         // read one row of the store
    logic rd_use_i;   // read address is the counter, else the candidate
    logic elim_step;  // candidate update and counter increment
    logic ver_init;   // check candidate row mask, counter to 0
    logic ver_step;   // check column bit of one row, counter increment
    logic emit;       // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_done;   // counter has reached n
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

// File: rtl/usf_datapath.sv
// Row store, candidate and counter registers, and result register.
module usf_datapath #(
  parameter int MAX_PEOPLE = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  usf_pkg::cmd_t               cmd,
  output usf_pkg::sts_t               sts,
  input  logic [usf_pkg::IDX_W-1:0]   row_index,
  input  logic [usf_pkg::ROW_W-1:0]   row_bits,
  input  logic                        cfg_we,
  input  logic [usf_pkg::COUNT_W-1:0] cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [usf_pkg::IDX_W-1:0]   out_index
);

  localparam int AW  = $clog2(MAX_PEOPLE);
  localparam int CAP = (MAX_PEOPLE < 32) ? MAX_PEOPLE : 32;
  localparam logic [usf_pkg::COUNT_W-1:0] CNT_CAP = usf_pkg::COUNT_W'(CAP);

  logic [usf_pkg::ROW_W-1:0]   mem [MAX_PEOPLE];
  logic [usf_pkg::ROW_W-1:0]   rd_data;
  logic [usf_pkg::COUNT_W-1:0] person_count;
  logic [usf_pkg::COUNT_W-1:0] n;
  logic [usf_pkg::COUNT_W-1:0] n_next;
  logic [usf_pkg::COUNT_W-1:0] i;
  logic [usf_pkg::IDX_W-1:0]   cand;
  logic                        ok;
  logic [usf_pkg::ROW_W:0]     col_mask;
  logic [usf_pkg::COUNT_W-1:0] rd_addr_wide;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               wr_addr;
  logic [usf_pkg::COUNT_W-1:0] wr_addr_wide;
  logic                        wr_in_range;

  always_comb begin
    if (person_count == '0) begin
      n_next = usf_pkg::COUNT_W'(1);
    end else if (person_count > CNT_CAP) begin
      n_next = CNT_CAP;
    end else begin
      n_next = person_count;
    end
  end

  assign wr_in_range  = {2'b00, row_index} < 7'(MAX_PEOPLE);
  assign wr_addr_wide = {1'b0, row_index};
  assign wr_addr      = wr_addr_wide[AW-1:0];
  assign rd_addr_wide = cmd.rd_use_i ? i : {1'b0, cand};
  assign rd_addr      = rd_addr_wide[AW-1:0];
  assign col_mask     = ((usf_pkg::ROW_W+1)'(1) << n) - (usf_pkg::ROW_W+1)'(1);

  assign sts.idx_done = (i >= n);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_in_range) begin
      mem[wr_addr] <= row_bits;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      person_count <= usf_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      person_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n    <= n_next;
      cand <= '0;
      i    <= usf_pkg::COUNT_W'(1);
    end else if (cmd.elim_step) begin
      if (rd_data[i[usf_pkg::IDX_W-1:0]]) begin
        cand <= i[usf_pkg::IDX_W-1:0];
      end
      i <= i + usf_pkg::COUNT_W'(1);
    end else if (cmd.ver_init) begin
      ok <= ((rd_data & col_mask[usf_pkg::ROW_W-1:0]) == '0);
      i  <= '0;
    end else if (cmd.ver_step) begin
      if ((i != {1'b0, cand}) && !rd_data[cand]) begin
        ok <= 1'b0;
      end
      i <= i + usf_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found <= ok;
      out_index <= ok ? cand : '0;
    end
  end

endmodule

// File: rtl/usf_ctrl.sv
// Controller state machine sequencing row loads, elimination and verification.
module usf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  usf_pkg::sts_t sts,
  output usf_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE, E_RD, E_EVAL, V_CAND_RD, V_MASK, V_RD, V_EVAL, FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        cmd.wr = accept;
        if (accept && in_last) begin
          cmd.start  = 1'b1;
          state_next = E_RD;
        end
      end
      E_RD: begin
        if (sts.idx_done) begin
          state_next = V_CAND_RD;
        end else begin
          cmd.rd     = 1'b1;
          state_next = E_EVAL;
        end
      end
      E_EVAL: begin
        cmd.elim_step = 1'b1;
        state_next    = E_RD;
      end
      V_CAND_RD: begin
        cmd.rd     = 1'b1;
        state_next = V_MASK;
      end
      V_MASK: begin
        cmd.ver_init = 1'b1;
        state_next   = V_RD;
      end
      V_RD: begin
        if (sts.idx_done) begin
          state_next = FINISH;
        end else begin
          cmd.rd       = 1'b1;
          cmd.rd_use_i = 1'b1;
          state_next   = V_EVAL;
        end
      end
      V_EVAL: begin
        cmd.ver_step = 1'b1;
        state_next   = V_RD;
      end
      FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/universal_sink_finder_unit.sv
// Top level of the universal sink finder: stream ports, controller and datapath.
// Rows that are not last are taken one per cycle while the controller is idle,
// and each is written to the row store as it is taken. After the last row the
// search runs elimination and then verification, reading one row per step from
// the single read port of the row store, each read followed by its evaluation. The result then sits in an
// output register. Reset clears the controller, the result valid flag, and sets
// the person count to 1; the row store is not cleared.
module universal_sink_finder_unit #(
  parameter int MAX_PEOPLE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,    // [4:0] row_index, [36:5] row_bits, zero fill
  input  logic        s_tlast,    // last_row
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [4:0] person_index, zero fill
  output logic [0:0]  m_tuser,    // [0] found
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata   // person_count
);

  usf_pkg::cmd_t cmd;
  usf_pkg::sts_t sts;
  logic          out_found;
  logic [4:0]    out_index;

  usf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  usf_datapath #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .row_index (s_tdata[4:0]),
    .row_bits  (s_tdata[36:5]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_found (out_found),
    .out_index (out_index)
  );

  assign m_tdata = {3'b000, out_index};
  assign m_tuser = out_found;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the universal sink finder: row loading, search, result stream.

typedef struct packed {
  logic       found;
  logic [4:0] idx;
} sink_answer_t;

// Keeps a copy of the knows matrix and the person count, and computes the
// sink expected for every last row.
class celebrity_tracker;
  logic [31:0]  knows_rows [32];
  logic [5:0]   person_count;
  sink_answer_t sink_answers [$];
  int           mismatches;

  function new();
    foreach (knows_rows[k]) knows_rows[k] = '0;
    person_count = 6'd1;
    mismatches = 0;
  endfunction

  function void set_count(logic [5:0] value);
    person_count = value;
  endfunction

  function int people();
    int n;
    n = person_count;
    if (n == 0) n = 1;
    if (n > 32) n = 32;
    return n;
  endfunction

  // Linear elimination, then a check of the candidate's row and column.
  function sink_answer_t find_sink();
    sink_answer_t answer;
    logic [31:0]  low_mask;
    int           n;
    int           cand;
    logic         ok;
    n = people();
    cand = 0;
    for (int i = 1; i < n; i++)
      if (knows_rows[cand][i]) cand = i;
    low_mask = (n == 32) ? 32'hFFFF_FFFF : (32'd1 << n) - 32'd1;
    ok = ((knows_rows[cand] & low_mask) == '0);
    for (int i = 0; i < n; i++)
      if (i != cand && !knows_rows[i][cand]) ok = 1'b0;
    answer.found = ok;
    answer.idx = ok ? 5'(cand) : 5'd0;
    return answer;
  endfunction

  function void note_row(logic [4:0] row, logic [31:0] bits, logic last);
    knows_rows[row] = bits;
    if (last) sink_answers.push_back(find_sink());
  endfunction

  function void check_answer(logic found, logic [4:0] idx);
    sink_answer_t want;
    if (sink_answers.size() == 0) begin
      $display("%0t: unexpected result found=%0b idx=%0d", $time, found, idx);
      mismatches++;
    end else begin
      want = sink_answers.pop_front();
      if (want.found !== found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, found);
        mismatches++;
      end
      if (want.idx !== idx) begin
        $display("%0t: person_index expected %0d actual %0d", $time, want.idx, idx);
        mismatches++;
      end
    end
  endfunction

  function int pending();
    return sink_answers.size();
  endfunction
endclass

module tb;

  localparam int SETTLE = 4 * 32 + 3 + 20;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  logic [5:0]  cfg_wdata;

  celebrity_tracker sb = new();

  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        hold_request;
  logic        hold_taken;
  int          hold_left;
  int          rows_sent;
  int          quiet_cycles;
  logic [31:0] written_rows;

  universal_sink_finder_unit #(.MAX_PEOPLE(32)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_answer(m_tuser[0], m_tdata[4:0]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  function automatic int people_of(int value);
    if (value == 0) return 1;
    if (value > 32) return 32;
    return value;
  endfunction

  task automatic send_row(input logic [4:0] row, input logic [31:0] bits, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, bits, row};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_row(row, bits, last);
    written_rows[row] = 1'b1;
    rows_sent++;
  endtask

  // Waits until every request has its answer and the search has wound down.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input logic [5:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(value);
  endtask

  // One complete matrix in shuffled row order; the final row carries tlast.
  task automatic send_frame(input int n);
    logic [31:0] rows [32];
    int          order [32];
    logic [31:0] low_mask;
    int          sink;
    int          style;
    int          j;
    int          tmp;
    low_mask = (n == 32) ? 32'hFFFF_FFFF : (32'd1 << n) - 32'd1;
    sink = $urandom_range(n - 1);
    style = $urandom_range(9);
    for (int k = 0; k < n; k++) begin
      case (style)
        7: rows[k] = $urandom;
        8: rows[k] = sink[0] ? 32'hFFFF_FFFF : 32'h0;
        9: rows[k] = $urandom & $urandom & $urandom;
        default: rows[k] = (k == sink) ? ($urandom & ~low_mask) : ($urandom | (32'd1 << sink));
      endcase
      order[k] = k;
    end
    // A single flipped bit usually spoils an otherwise planted sink.
    if (style == 6) begin
      j = $urandom_range(n - 1);
      rows[j] = rows[j] ^ (32'd1 << $urandom_range(n - 1));
    end
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < n; k++) send_row(5'(order[k]), rows[order[k]], k == n - 1);
  endtask

  task automatic run_phase(input int count, input int items, input logic squeeze);
    int          n;
    int          target;
    int          pick;
    int          burst;
    logic [31:0] low_mask;
    drain();
    write_count(6'(count));
    n = people_of(count);
    low_mask = (n == 32) ? 32'hFFFF_FFFF : (32'd1 << n) - 32'd1;
    target = rows_sent + items;
    if (squeeze) hold_request = 1'b1;
    while (rows_sent < target) begin
      pick = $urandom_range(9);
      burst = $urandom_range(1, 3);
      if (pick == 0) begin
        for (int k = 0; k < burst; k++)
          send_row(5'(n < 32 ? $urandom_range(31, n) : $urandom_range(31)), $urandom, 1'b0);
      end else if (pick == 1 && (written_rows & low_mask) == low_mask) begin
        // Partial update of a matrix that is already complete in the store.
        for (int k = 0; k < burst; k++)
          send_row(5'($urandom_range(31)), $urandom, k == burst - 1);
      end else begin
        send_frame(n);
      end
    end
  endtask

  initial begin
    int counts [9];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_request = 1'b0;
    rows_sent = 0;
    written_rows = '0;
    tx_idle_pct = 15;
    rx_idle_pct = 82;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One person after reset: the diagonal bit alone decides.
    send_row(5'd0, 32'h0, 1'b1);
    send_row(5'd0, 32'h1, 1'b1);
    send_row(5'd0, 32'hFFFF_FFFE, 1'b1);
    send_row(5'd31, 32'hFFFF_FFFF, 1'b0);
    send_row(5'd0, 32'h0, 1'b1);
    // A count of zero behaves as one person.
    drain();
    write_count(6'd0);
    send_row(5'd0, 32'h8000_0000, 1'b1);
    drain();
    write_count(6'd3);
    send_row(5'd0, 32'h4, 1'b0);
    send_row(5'd1, 32'h4, 1'b0);
    send_row(5'd2, 32'h0, 1'b1);
    send_row(5'd2, 32'h4, 1'b1);
    send_row(5'd2, 32'hFFFF_FFF8, 1'b1);
    send_row(5'd1, 32'h1, 1'b1);
    send_row(5'd0, 32'h0, 1'b0);
    send_row(5'd1, 32'h1, 1'b0);
    send_row(5'd2, 32'h1, 1'b1);
    drain();
    write_count(6'd2);
    send_row(5'd0, 32'h2, 1'b0);
    send_row(5'd1, 32'h1, 1'b1);

    counts = '{5, 0, 3, 8, 32, 2, 63, 1, 2};
    counts[8] = $urandom_range(2, 12);
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        tx_idle_pct = 82;
        rx_idle_pct = 15;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_phase(counts[p], 115, p == 7);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
